/* rtl/acl_pkg.sv */
// Shared types and constants for the ACL permission evaluator.
`default_nettype none
package acl_pkg;
  localparam int MAX_ENTRIES_DEF = 64;
  localparam int MAX_GROUPS_DEF  = 32;
  localparam int FIFO_DEPTH      = 2;

  localparam logic [1:0] MODE_ENTRY = 2'd0;
  localparam logic [1:0] MODE_GROUP = 2'd1;
  localparam logic [1:0] MODE_EVAL  = 2'd2;

  localparam logic [2:0] KIND_OWNER   = 3'd0;
  localparam logic [2:0] KIND_OWN_GRP = 3'd1;
  localparam logic [2:0] KIND_EVERY   = 3'd2;
  localparam logic [2:0] KIND_USER    = 3'd3;
  localparam logic [2:0] KIND_GROUP   = 3'd4;

  localparam logic [2:0] REG_MODE    = 3'd0;
  localparam logic [2:0] REG_OWNMASK = 3'd1;
  localparam logic [2:0] REG_GRPMASK = 3'd2;
  localparam logic [2:0] REG_OTHMASK = 3'd3;
  localparam logic [2:0] REG_OWNER   = 3'd4;
  localparam logic [2:0] REG_GROUP   = 3'd5;
  localparam logic [2:0] REG_VALID   = 3'd6;
  localparam logic [2:0] REG_CLEAR   = 3'd7;

  // Queued word from front to back.
  typedef struct packed {
    logic [1:0]  mode;
    logic [5:0]  slot;
    logic [4:0]  kind;
    logic [31:0] bits;
    logic [31:0] ident;
    logic [31:0] user;
    logic [6:0]  nent;
    logic [5:0]  ngrp;
  } cmd_t;

  // Configuration register set.
  typedef struct packed {
    logic [1:0]  flags;
    logic [31:0] own_mask;
    logic [31:0] grp_mask;
    logic [31:0] oth_mask;
    logic [31:0] owner_id;
    logic [31:0] group_id;
    logic [31:0] valid_mask;
    logic [31:0] clear_mask;
  } cfg_t;
endpackage
`default_nettype wire

/* rtl/acl_front.sv */
// Front end: accepts words, saturates counts, queues commands.
`default_nettype none
module acl_front #(
  parameter int MAX_ENTRIES = acl_pkg::MAX_ENTRIES_DEF,
  parameter int MAX_GROUPS  = acl_pkg::MAX_GROUPS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  output logic              busy,
  input  wire logic [1:0]   mode,
  input  wire logic [5:0]   slot,
  input  wire logic [2:0]   ace_kind,
  input  wire logic         ace_allow,
  input  wire logic         ace_inherit_only,
  input  wire logic [31:0]  ace_bits,
  input  wire logic [31:0]  ace_id,
  input  wire logic [31:0]  process_group,
  input  wire logic [31:0]  request_user,
  input  wire logic [6:0]   entry_count,
  input  wire logic [5:0]   group_count,
  output acl_pkg::cmd_t     q_data,
  output logic              q_valid,
  input  wire logic         q_pop
);
  import acl_pkg::*;
  localparam int PW = $clog2(FIFO_DEPTH);

  cmd_t            mem [FIFO_DEPTH];
  logic [PW-1:0]   wp, rp;
  logic [PW:0]     cnt;
  cmd_t            c;
  logic            push;

  // Build command; counts saturate, group load reuses the bits field.
  always_comb begin
    c.mode  = mode;
    c.slot  = slot;
    c.kind  = {ace_inherit_only, ace_allow, ace_kind};
    c.bits  = (mode == MODE_GROUP) ? process_group : ace_bits;
    c.ident = ace_id;
    c.user  = request_user;
    c.nent  = (32'(entry_count) > MAX_ENTRIES) ? 7'(MAX_ENTRIES) : entry_count;
    c.ngrp  = (32'(group_count) > MAX_GROUPS) ? 6'(MAX_GROUPS) : group_count;
  end

  assign busy    = (cnt == (PW+1)'(FIFO_DEPTH));
  assign push    = start && !busy && (mode != 2'd3);
  assign q_valid = (cnt != '0);
  assign q_data  = mem[rp];

  // Queue storage and pointers.
  always_ff @(posedge clk) begin
    if (push) mem[wp] <= c;
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (q_pop) rp <= rp + 1'b1;
      cnt <= cnt + (PW+1)'(push) - (PW+1)'(q_pop);
    end
  end

  a_no_over: assert property (@(posedge clk) disable iff (rst)
    busy |-> !push) else $error("push into full queue");
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_cnt_rng: assert property (@(posedge clk) disable iff (rst)
    cnt <= (PW+1)'(FIFO_DEPTH)) else $error("queue count overflow");
endmodule
`default_nettype wire

/* rtl/acl_back.sv */
// Back end: table stores and the sequential entry walk.
`default_nettype none
module acl_back #(
  parameter int MAX_ENTRIES = acl_pkg::MAX_ENTRIES_DEF,
  parameter int MAX_GROUPS  = acl_pkg::MAX_GROUPS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  acl_pkg::cmd_t    q_data,
  input  wire logic        q_valid,
  output logic             q_pop,
  input  acl_pkg::cfg_t    cfg,
  output logic             done,
  output logic [31:0]      granted_bits
);
  import acl_pkg::*;
  localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_READ = 4'b0010, S_WALK = 4'b0100, S_FIN = 4'b1000
  } state_t;

  state_t state;
  logic [31:0] ebits [MAX_ENTRIES];
  logic [31:0] eid   [MAX_ENTRIES];
  logic [4:0]  ekind [MAX_ENTRIES];
  logic [31:0] gstore [MAX_GROUPS];

  logic [31:0] rd_bits, rd_id, user, undec, allowed;
  logic [4:0]  rd_kind;
  logic [6:0]  idx, nent;
  logic [5:0]  ngrp;
  logic        is_owner, in_own, in_class;
  logic        masked, wthru;

  assign masked = cfg.flags[0];
  assign wthru  = cfg.flags[1];

  // Parallel group membership test.
  function automatic logic member(input logic [31:0] gid, input logic [5:0] n,
                                  input logic [31:0] gs [MAX_GROUPS]);
    logic m;
    m = 1'b0;
    for (int i = 0; i < MAX_GROUPS; i++)
      if ((i < 32'(n)) && (gs[i] == gid)) m = 1'b1;
    return m;
  endfunction

  // Store writes from load words.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid) begin
      if (q_data.mode == MODE_ENTRY && 32'(q_data.slot) < MAX_ENTRIES) begin
        ebits[EW'(q_data.slot)] <= q_data.bits;
        eid[EW'(q_data.slot)]   <= q_data.ident;
        ekind[EW'(q_data.slot)] <= q_data.kind;
      end
      if (q_data.mode == MODE_GROUP && 32'(q_data.slot) < MAX_GROUPS)
        gstore[GW'(q_data.slot)] <= q_data.bits;
    end
  end

  // Registered entry read.
  always_ff @(posedge clk) begin
    rd_bits <= ebits[idx[EW-1:0]];
    rd_id   <= eid[idx[EW-1:0]];
    rd_kind <= ekind[idx[EW-1:0]];
  end

  logic match, glike, stop;
  logic [31:0] b, und_n, all_n;
  logic        cls_n;
  always_comb begin
    match = 1'b0; glike = 1'b0; cls_n = in_class;
    case (rd_kind[2:0])
      KIND_OWNER:   begin match = is_owner; cls_n = cls_n | is_owner; end
      KIND_OWN_GRP: begin match = in_own; glike = 1'b1; end
      KIND_EVERY:   match = 1'b1;
      KIND_USER:    begin match = (user == rd_id); cls_n = cls_n | match; end
      KIND_GROUP:   begin match = member(rd_id, ngrp, gstore); glike = 1'b1; end
      default:      match = 1'b0;
    endcase
    if (rd_kind[4]) match = 1'b0;
    if (!match) cls_n = in_class;
    else if (glike) cls_n = 1'b1;
    b = (glike && masked && rd_kind[3]) ? (rd_bits & cfg.grp_mask) : rd_bits;
    und_n = match ? (undec & ~b) : undec;
    all_n = (match && rd_kind[3]) ? (allowed | (b & undec)) : allowed;
    stop = (und_n == '0) && cls_n;
  end

  logic [31:0] fin;
  always_comb begin
    fin = allowed;
    if (masked) begin
      if (is_owner) fin = allowed & cfg.own_mask;
      else if (in_class) fin = allowed & cfg.grp_mask;
      else if (wthru) fin = cfg.oth_mask;
      else fin = allowed & cfg.oth_mask;
    end
  end

  assign q_pop = (state == S_IDLE) && q_valid;

  // Walk sequencer.
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      idx <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          idx <= '0;
          if (q_valid && q_data.mode == MODE_EVAL) begin
            user     <= q_data.user;
            nent     <= q_data.nent;
            ngrp     <= q_data.ngrp;
            is_owner <= (q_data.user == cfg.owner_id);
            in_own   <= member(cfg.group_id, q_data.ngrp, gstore);
            in_class <= !masked || member(cfg.group_id, q_data.ngrp, gstore);
            undec    <= cfg.valid_mask;
            allowed  <= '0;
            if (masked && wthru && q_data.user == cfg.owner_id) begin
              granted_bits <= cfg.own_mask;
              done <= 1'b1;
            end else if (q_data.nent == '0) begin
              state <= S_FIN;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          idx <= idx + 1'b1;
          state <= S_WALK;
        end
        S_WALK: begin
          undec <= und_n; allowed <= all_n; in_class <= cls_n;
          if (stop || idx == nent) state <= S_FIN;
          else state <= S_READ;
        end
        S_FIN: begin
          granted_bits <= fin & ~cfg.clear_mask;
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == S_IDLE) else $error("pop while walking");
  a_idx_rng: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |-> idx <= nent) else $error("walk past entry count");
  a_done_fin: assert property (@(posedge clk) disable iff (rst)
    $past(state) == S_FIN |-> done) else $error("finish without result");
endmodule
`default_nettype wire

/* rtl/acl_permission_evaluator_unit.sv */
// Top level of the ACL permission evaluator.
// Usage: an input word is taken when start is high and busy is low.
// mode 0 loads an entry at slot, mode 1 loads a process group, mode 2
// evaluates request_user against the first entry_count entries; mode 3
// is dropped. Only an evaluation yields a result: granted_bits with
// done high for exactly one cycle; the receiver cannot stall.
// Words pass a two-deep queue to the back end, which walks the entries
// one at a time, each by a registered table read and then an update;
// an early stop can end the walk before the last entry. Group
// membership is tested in parallel against the group store. A load
// is written to its store while the back end is idle.
// busy is high while the queue is full.
// Registers sit on an APB port at 4*index; pready is always high.
// Synchronous reset clears the queue, walker and registers (valid mask
// to all ones); table and group stores are undefined until written.
`default_nettype none
module acl_permission_evaluator_unit #(
  parameter int MAX_ENTRIES = acl_pkg::MAX_ENTRIES_DEF,
  parameter int MAX_GROUPS  = acl_pkg::MAX_GROUPS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  mode,
  input  wire logic [5:0]  slot,
  input  wire logic [2:0]  ace_kind,
  input  wire logic        ace_allow,
  input  wire logic        ace_inherit_only,
  input  wire logic [31:0] ace_bits,
  input  wire logic [31:0] ace_id,
  input  wire logic [31:0] process_group,
  input  wire logic [31:0] request_user,
  input  wire logic [6:0]  entry_count,
  input  wire logic [5:0]  group_count,
  output logic             done,
  output logic [31:0]      granted_bits,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import acl_pkg::*;

  cfg_t  cfg;
  cmd_t  q_data;
  logic  q_valid, q_pop, wr;
  logic [2:0] ra;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign ra = paddr[4:2];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flags      <= '0;
      cfg.own_mask   <= '0;
      cfg.grp_mask   <= '0;
      cfg.oth_mask   <= '0;
      cfg.owner_id   <= '0;
      cfg.group_id   <= '0;
      cfg.valid_mask <= '1;
      cfg.clear_mask <= '0;
    end else if (wr) begin
      case (ra)
        REG_MODE:    cfg.flags      <= pwdata[1:0];
        REG_OWNMASK: cfg.own_mask   <= pwdata;
        REG_GRPMASK: cfg.grp_mask   <= pwdata;
        REG_OTHMASK: cfg.oth_mask   <= pwdata;
        REG_OWNER:   cfg.owner_id   <= pwdata;
        REG_GROUP:   cfg.group_id   <= pwdata;
        REG_VALID:   cfg.valid_mask <= pwdata;
        REG_CLEAR:   cfg.clear_mask <= pwdata;
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (ra)
      REG_MODE:    prdata = {30'd0, cfg.flags};
      REG_OWNMASK: prdata = cfg.own_mask;
      REG_GRPMASK: prdata = cfg.grp_mask;
      REG_OTHMASK: prdata = cfg.oth_mask;
      REG_OWNER:   prdata = cfg.owner_id;
      REG_GROUP:   prdata = cfg.group_id;
      REG_VALID:   prdata = cfg.valid_mask;
      REG_CLEAR:   prdata = cfg.clear_mask;
      default:     prdata = '0;
    endcase
  end

  acl_front #(.MAX_ENTRIES(MAX_ENTRIES), .MAX_GROUPS(MAX_GROUPS)) u_front (
    .clk, .rst, .start, .busy, .mode, .slot, .ace_kind, .ace_allow,
    .ace_inherit_only, .ace_bits, .ace_id, .process_group, .request_user,
    .entry_count, .group_count, .q_data, .q_valid, .q_pop
  );

  acl_back #(.MAX_ENTRIES(MAX_ENTRIES), .MAX_GROUPS(MAX_GROUPS)) u_back (
    .clk, .rst, .q_data, .q_valid, .q_pop, .cfg, .done, .granted_bits
  );
endmodule
`default_nettype wire

/* sim/acl_permission_evaluator_unit_tb.sv */
// Self-checking testbench for the ACL permission evaluator: APB setup, command words, scoreboard.
`default_nettype none

// Predicts granted bits from its own copy of the tables and registers.
class acl_scoreboard;
  logic [31:0] ent_bits [64];
  logic [31:0] ent_id [64];
  logic [4:0]  ent_kind [64];
  logic [31:0] grp_ids [32];
  logic [1:0]  flags;
  logic [31:0] own_m, grp_m, oth_m, owner_id, group_id, valid_m, clear_m;
  logic [31:0] grant_q [$];
  int errors;
  int checked;

  function new();
    flags = 0; own_m = 0; grp_m = 0; oth_m = 0;
    owner_id = 0; group_id = 0; valid_m = '1; clear_m = 0;
    errors = 0; checked = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [31:0] v);
    case (idx)
      acl_pkg::REG_MODE:    flags = v[1:0];
      acl_pkg::REG_OWNMASK: own_m = v;
      acl_pkg::REG_GRPMASK: grp_m = v;
      acl_pkg::REG_OTHMASK: oth_m = v;
      acl_pkg::REG_OWNER:   owner_id = v;
      acl_pkg::REG_GROUP:   group_id = v;
      acl_pkg::REG_VALID:   valid_m = v;
      default:              clear_m = v;
    endcase
  endfunction

  function bit has_group(logic [31:0] gid, int n);
    for (int i = 0; i < n; i++)
      if (grp_ids[i] == gid) return 1;
    return 0;
  endfunction

  function logic [31:0] grant(logic [31:0] user, int nent, int ngrp);
    bit masked, wthru, is_owner, in_own, in_cls, grp_like, allow;
    logic [31:0] undec, allowed, b;
    logic [2:0] k;
    masked = flags[0];
    wthru = flags[1];
    is_owner = (user == owner_id);
    in_own = has_group(group_id, ngrp);
    in_cls = masked ? in_own : 1'b1;
    undec = valid_m;
    allowed = 0;
    if (masked && wthru && is_owner) return own_m;
    for (int i = 0; i < nent; i++) begin
      if (ent_kind[i][4]) continue;
      k = ent_kind[i][2:0];
      allow = ent_kind[i][3];
      b = ent_bits[i];
      grp_like = 0;
      case (k)
        acl_pkg::KIND_OWNER: begin
          if (!is_owner) continue;
          in_cls = 1;
        end
        acl_pkg::KIND_OWN_GRP: begin
          if (!in_own) continue;
          grp_like = 1;
        end
        acl_pkg::KIND_USER: begin
          if (user != ent_id[i]) continue;
          in_cls = 1;
        end
        acl_pkg::KIND_GROUP: begin
          if (!has_group(ent_id[i], ngrp)) continue;
          grp_like = 1;
        end
        acl_pkg::KIND_EVERY: ;
        default: continue;
      endcase
      if (grp_like) begin
        if (masked && allow) b &= grp_m;
        in_cls = 1;
      end
      if (allow) allowed |= b & undec;
      undec &= ~b;
      if (undec == 0 && in_cls) break;
    end
    if (masked) begin
      if (is_owner) allowed &= own_m;
      else if (in_cls) allowed &= grp_m;
      else if (wthru) allowed = oth_m;
      else allowed &= oth_m;
    end
    return allowed & ~clear_m;
  endfunction

  // Accepted command word: update tables or queue the expected grant.
  function void note_word(logic [1:0] md, logic [5:0] sl, logic [2:0] kd, logic al,
                          logic inh, logic [31:0] bits, logic [31:0] id,
                          logic [31:0] pg, logic [31:0] user, logic [6:0] ec,
                          logic [5:0] gc);
    int ne, ng;
    case (md)
      acl_pkg::MODE_ENTRY: begin
        ent_kind[sl] = {inh, al, kd};
        ent_bits[sl] = bits;
        ent_id[sl] = id;
      end
      acl_pkg::MODE_GROUP: if (sl < 32) grp_ids[sl] = pg;
      acl_pkg::MODE_EVAL: begin
        ne = (ec > 64) ? 64 : ec;
        ng = (gc > 32) ? 32 : gc;
        grant_q.push_back(grant(user, ne, ng));
      end
      default: ;
    endcase
  endfunction

  function void check_word(logic [31:0] got);
    logic [31:0] exp_bits;
    if (grant_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, actual %h", $time, got);
      return;
    end
    exp_bits = grant_q.pop_front();
    checked++;
    if (got !== exp_bits) begin
      errors++;
      $display("%0t: granted_bits mismatch, expected %h, actual %h", $time, exp_bits, got);
    end
  endfunction
endclass

module acl_permission_evaluator_unit_tb;
  import acl_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [1:0]  mode;
    logic [5:0]  slot;
    logic [2:0]  kind;
    logic        allow;
    logic        inh;
    logic [31:0] bits;
    logic [31:0] id;
    logic [31:0] pg;
    logic [31:0] user;
    logic [6:0]  ecount;
    logic [5:0]  gcount;
  } word_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic [1:0] mode = 0;
  logic [5:0] slot = 0;
  logic [2:0] ace_kind = 0;
  logic ace_allow = 0;
  logic ace_inherit_only = 0;
  logic [31:0] ace_bits = 0;
  logic [31:0] ace_id = 0;
  logic [31:0] process_group = 0;
  logic [31:0] request_user = 0;
  logic [6:0] entry_count = 0;
  logic [5:0] group_count = 0;
  logic psel = 0;
  logic penable = 0;
  logic pwrite = 0;
  logic [4:0] paddr = 0;
  logic [31:0] pwdata = 0;
  wire busy, done, pready;
  wire [31:0] granted_bits, prdata;

  acl_scoreboard sb = new();
  logic [31:0] id_pool [8] = '{32'd0, 32'hFFFFFFFF, 32'd5, 32'd7, 32'd100, 32'd1000,
                               32'h80000000, 32'd42};
  int idle_pct = 0;
  int n_words = 0;
  int n_evals = 0;
  longint cycles = 0;

  acl_permission_evaluator_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode), .slot(slot),
    .ace_kind(ace_kind), .ace_allow(ace_allow), .ace_inherit_only(ace_inherit_only),
    .ace_bits(ace_bits), .ace_id(ace_id), .process_group(process_group),
    .request_user(request_user), .entry_count(entry_count), .group_count(group_count),
    .done(done), .granted_bits(granted_bits), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Result monitor and run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) sb.check_word(granted_bits);
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  function logic [31:0] pick_id();
    return ($urandom_range(99) < 75) ? id_pool[$urandom_range(7)] : $urandom;
  endfunction

  // Drive one word, hold it until taken, then maybe idle the sender.
  task send_word(word_t w);
    @(negedge clk);
    start <= 1; mode <= w.mode; slot <= w.slot; ace_kind <= w.kind;
    ace_allow <= w.allow; ace_inherit_only <= w.inh; ace_bits <= w.bits;
    ace_id <= w.id; process_group <= w.pg; request_user <= w.user;
    entry_count <= w.ecount; group_count <= w.gcount;
    do @(posedge clk); while (busy);
    sb.note_word(w.mode, w.slot, w.kind, w.allow, w.inh, w.bits, w.id, w.pg,
                 w.user, w.ecount, w.gcount);
    n_words++;
    if (w.mode == MODE_EVAL) n_evals++;
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 0;
      repeat ($urandom_range(4)) @(negedge clk);
    end
  endtask

  function word_t entry_word(int sl, logic [2:0] k, logic al, logic inh, logic [31:0] b,
                             logic [31:0] id);
    word_t w;
    w = '{default: 0};
    w.mode = MODE_ENTRY; w.slot = 6'(sl); w.kind = k; w.allow = al; w.inh = inh;
    w.bits = b; w.id = id; w.pg = $urandom; w.user = $urandom;
    return w;
  endfunction

  function word_t eval_word(logic [31:0] user, logic [6:0] ec, logic [5:0] gc);
    word_t w;
    w = '{default: 0};
    w.mode = MODE_EVAL; w.user = user; w.ecount = ec; w.gcount = gc;
    w.slot = 6'($urandom); w.bits = $urandom; w.id = $urandom;
    return w;
  endfunction

  function word_t rand_word();
    word_t w;
    int r;
    logic [31:0] b;
    r = $urandom_range(99);
    if (r < 40) begin
      case ($urandom_range(3))
        0, 1: b = $urandom;
        2: b = '1;
        default: b = $urandom_range(255);
      endcase
      w = entry_word(($urandom_range(99) < 70) ? $urandom_range(15) : $urandom_range(63),
                     3'($urandom_range(5)), 1'($urandom_range(1)),
                     ($urandom_range(9) == 0), b, pick_id());
    end else if (r < 52) begin
      w = entry_word($urandom_range(63), KIND_OWNER, 1'b0, 1'b0, $urandom, $urandom);
      w.mode = MODE_GROUP;
      w.pg = pick_id();
    end else if (r < 97) begin
      r = $urandom_range(99);
      w = eval_word(($urandom_range(99) < 75) ? pick_id() : $urandom,
                    7'((r < 85) ? $urandom_range(16) : (r < 95) ? $urandom_range(64)
                                                                : $urandom_range(127)),
                    6'(($urandom_range(99) < 80) ? $urandom_range(8)
                                                 : $urandom_range(63)));
    end else begin
      w = eval_word($urandom, 7'($urandom), 6'($urandom));
      w.mode = 2'd3;
    end
    return w;
  endfunction

  // APB write: setup cycle, then access cycle
  task reg_write(logic [2:0] idx, logic [31:0] v);
    @(negedge clk);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= v;
    @(negedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, v);
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // Sender pauses until every grant is back and the walker has settled.
  task drain();
    @(negedge clk);
    start <= 0;
    while (sb.grant_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task set_phase(int p);
    logic [31:0] mval;
    mval = (p == 1) ? '1 : (p == 2) ? 32'd0 : $urandom;
    reg_write(REG_MODE, (p == 5) ? 32'd3 : p % 4);
    reg_write(REG_OWNMASK, mval);
    reg_write(REG_GRPMASK, (p == 2) ? 32'd0 : $urandom);
    reg_write(REG_OTHMASK, (p == 1) ? 32'hFFFFFFFF : $urandom);
    reg_write(REG_OWNER, ($urandom_range(3) == 0) ? $urandom : id_pool[$urandom_range(7)]);
    reg_write(REG_GROUP, id_pool[$urandom_range(7)]);
    reg_write(REG_VALID, (p == 3) ? 32'hFF : (p == 4) ? 32'hFFFFFFFF : $urandom | 32'hF);
    reg_write(REG_CLEAR, (p == 1) ? 32'd0 : (p == 2) ? 32'hFFFFFFFF : 32'h00000040);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Fill the entry store so no evaluation reads an unwritten slot
    for (int i = 0; i < 64; i++) begin
      send_word(entry_word(i, 3'($urandom_range(5)), 1'($urandom_range(1)), 1'b0,
                           $urandom, pick_id()));
    end
    for (int i = 0; i < 32; i++) begin
      send_word(entry_word(i, KIND_OWNER, 1'b0, 1'b0, 32'd0, 32'd0));
    end

    // Directed: group loads into real and ignored slots
    for (int i = 0; i < 32; i++) begin
      word_t g;
      g = entry_word(i, KIND_OWNER, 1'b0, 1'b0, 32'd0, 32'd0);
      g.mode = MODE_GROUP;
      g.pg = id_pool[i % 8];
      send_word(g);
    end
    begin
      word_t g;
      g = entry_word(63, KIND_OWNER, 1'b0, 1'b0, 32'd0, 32'd0);
      g.mode = MODE_GROUP;
      g.pg = 32'hDEADBEEF;
      send_word(g);
      g.mode = 2'd3;
      send_word(g);
    end
    // Directed: skipped kinds, inherit-only, extremes of bits and counts
    send_word(entry_word(0, 3'd5, 1'b1, 1'b0, 32'hFFFFFFFF, 32'd0));
    send_word(entry_word(1, KIND_EVERY, 1'b1, 1'b1, 32'hFFFFFFFF, 32'd0));
    send_word(entry_word(2, KIND_OWNER, 1'b0, 1'b0, 32'h0000000F, 32'hFFFFFFFF));
    send_word(entry_word(3, KIND_EVERY, 1'b1, 1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF));
    send_word(entry_word(4, KIND_GROUP, 1'b1, 1'b0, 32'h0, 32'd5));
    send_word(eval_word(32'd0, 7'd0, 6'd0));
    send_word(eval_word(32'd0, 7'd4, 6'd32));
    send_word(eval_word(32'hFFFFFFFF, 7'd64, 6'd63));
    send_word(eval_word(32'd5, 7'd127, 6'd33));
    send_word(eval_word(32'd42, 7'd5, 6'd1));
    drain();

    // Random phases over several register settings
    for (int p = 0; p < 6; p++) begin
      idle_pct = (p < 2) ? 25 : (p < 4) ? 69 : 0;
      if (p > 0) set_phase(p);
      for (int i = 0; i < 300; i++) send_word(rand_word());
      drain();
    end

    $display("ran %0d words (%0d evaluations, %0d grants checked) over six register settings",
             n_words, n_evals, sb.checked);
    if (sb.errors == 0 && sb.grant_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d grants missing", sb.errors, sb.grant_q.size());
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

`default_nettype wire

/* files.f */
rtl/acl_pkg.sv
rtl/acl_front.sv
rtl/acl_back.sv
rtl/acl_permission_evaluator_unit.sv
sim/acl_permission_evaluator_unit_tb.sv
